// ----- hdl/sha_pkg.sv -----
// sha_pkg: shared types, constants and functions for the sha-256 hasher
// no dependencies
`default_nettype none
package sha_pkg;

    localparam int RoundCount = 64;
    localparam int BlockBytes = 64;
    localparam int HashWords  = 8;

    typedef enum logic [1:0] {
        OP_APPEND  = 2'd0,
        OP_FINISH  = 2'd1,
        OP_RESTART = 2'd2,
        OP_NONE    = 2'd3
    } opcode_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
        logic        status;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROUNDS,
        ST_PAD_BYTE,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_FINAL_ROUNDS,
        ST_EMIT,
        ST_REJECT
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic       restart;     // load initial hash, clear counts
        logic       wr_byte;     // shift byte into the block window
        logic [7:0] wr_data;
        logic       count_bits;  // advance bit counter by 8
        logic       start_block; // load working vars from hash
        logic       round;       // run one round
        logic       fold;        // add working vars into hash
        logic       clear_fill;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic        block_full;  // next byte write completes the block
        logic        last_round;
        logic [5:0]  fill;
        logic [63:0] total_bits;
    } dp_stat_t;

    localparam logic [31:0] RoundK [RoundCount] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] InitH [HashWords] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PadByte   = 8'h80;
    localparam logic [5:0] LenOffset = 6'd56;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

endpackage
`default_nettype wire

// ----- hdl/sha256_hasher_top.sv -----
// sha256_hasher_top: sha-256 hasher fed one byte per transaction
// depends on sha_pkg, sha_ctrl, sha_datapath
//
// input channel in_valid/in_stall carries in_item (opcode, data_byte).
// append writes one byte; each 64th byte starts a compression (load,
// 64 rounds, hash fold) during which in_stall is high.
// finish writes the padding one byte per cycle, compresses one or two
// blocks and then offers eight digest words on out_valid/out_stall,
// word 0 first, last_word on word 7. append or finish after finish gives
// one result with status 1. restart clears the hash.
// a plain append leaves in_stall low; after a finish in_stall stays high
// through the padding writes, the one or two compressions on the single
// shared round unit and the digest output, with any output stalls.
// at most one transaction is in flight; while the receiver stalls an
// output the word is held and no input is taken.
// reset loads the initial hash values and clears counts and the
// finished flag; the byte buffer is not cleared.
`default_nettype none
module sha256_hasher_top
    import sha_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    input  wire in_item_t in_item,
    output logic      out_valid,
    input  wire logic out_stall,
    output out_item_t out_item
);

    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic [2:0]  rd_index;
    logic [31:0] rd_word;

    sha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cmd       (cmd),
        .stat      (stat),
        .rd_index  (rd_index),
        .rd_word   (rd_word)
    );

    sha_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .rd_index (rd_index),
        .stat     (stat),
        .rd_word  (rd_word)
    );

endmodule
`default_nettype wire

// ----- hdl/sha_datapath.sv -----
// sha_datapath: block window, message schedule, round unit and hash words
// depends on sha_pkg
`default_nettype none
module sha_datapath
    import sha_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire dp_cmd_t  cmd,
    input  wire logic [2:0] rd_index,
    output dp_stat_t      stat,
    output logic [31:0]   rd_word
);

    logic [31:0] hash_reg [HashWords];
    logic [31:0] v_reg [HashWords];
    logic [31:0] w_reg [16];
    logic [5:0]  fill_reg;
    logic [5:0]  round_reg;
    logic [63:0] bits_reg;

    logic [31:0] big1, big0, chs, mj, t1, t2, sa, sb, w_new;
    always_comb
    begin
        big1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        chs  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1   = v_reg[7] + big1 + chs + RoundK[round_reg] + w_reg[0];
        big0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        mj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2   = big0 + mj;
        sa   = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        sb   = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + sa + w_reg[9] + sb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            bits_reg  <= '0;
            round_reg <= '0;
            for (int i = 0; i < HashWords; i++)
            begin
                hash_reg[i] <= InitH[i];
            end
        end
        else
        begin
            if (cmd.restart)
            begin
                fill_reg <= '0;
                bits_reg <= '0;
                for (int i = 0; i < HashWords; i++)
                begin
                    hash_reg[i] <= InitH[i];
                end
            end
            else
            begin
                if (cmd.clear_fill)
                begin
                    fill_reg <= '0;
                end
                else if (cmd.wr_byte)
                begin
                    fill_reg <= fill_reg + 6'd1;
                end
                if (cmd.count_bits)
                begin
                    bits_reg <= bits_reg + 64'd8;
                end
                if (cmd.fold)
                begin
                    for (int i = 0; i < HashWords; i++)
                    begin
                        hash_reg[i] <= hash_reg[i] + v_reg[i];
                    end
                end
            end
            if (cmd.start_block)
            begin
                round_reg <= '0;
            end
            else if (cmd.round)
            begin
                round_reg <= round_reg + 6'd1;
            end
        end
    end

    // bytes shift into the 16-word schedule window, so after 64 writes it
    // holds the block with byte 0 at the top of word 0; rounds shift words
    always_ff @(posedge clk)
    begin
        if (cmd.start_block)
        begin
            for (int i = 0; i < HashWords; i++)
            begin
                v_reg[i] <= hash_reg[i];
            end
        end
        else if (cmd.round)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        if (cmd.wr_byte)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= {w_reg[i][23:0], w_reg[i+1][31:24]};
            end
            w_reg[15] <= {w_reg[15][23:0], cmd.wr_data};
        end
        else if (cmd.round)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_new;
        end
    end

    assign stat.block_full = (fill_reg == 6'd63);
    assign stat.last_round = (round_reg == 6'(RoundCount - 1));
    assign stat.fill       = fill_reg;
    assign stat.total_bits = bits_reg;
    assign rd_word         = hash_reg[rd_index];

endmodule
`default_nettype wire

// ----- hdl/sha_ctrl.sv -----
// sha_ctrl: controller state machine for input, padding and digest output
// depends on sha_pkg
`default_nettype none
module sha_ctrl
    import sha_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    input  wire in_item_t in_item,
    output logic       out_valid,
    input  wire logic  out_stall,
    output out_item_t  out_item,
    output dp_cmd_t    cmd,
    input  wire dp_stat_t stat,
    output logic [2:0] rd_index,
    input  wire logic [31:0] rd_word
);

    ctrl_state_t state_reg, state_next;
    logic        done_reg, done_next;
    logic        extra_reg, extra_next;  // a length block still follows
    logic [2:0]  idx_reg, idx_next;
    logic [2:0]  len_reg, len_next;
    logic        accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            extra_reg <= 1'b0;
            idx_reg   <= '0;
            len_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            extra_reg <= extra_next;
            idx_reg   <= idx_next;
            len_reg   <= len_next;
        end
    end

    assign accept   = in_valid && !in_stall;
    assign rd_index = idx_reg;

    always_comb
    begin
        state_next = state_reg;
        done_next  = done_reg;
        extra_next = extra_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        out_item   = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    case (opcode_t'(in_item.opcode))
                        OP_APPEND:
                        begin
                            if (done_reg)
                            begin
                                state_next = ST_REJECT;
                            end
                            else
                            begin
                                cmd.wr_byte    = 1'b1;
                                cmd.wr_data    = in_item.data_byte;
                                cmd.count_bits = 1'b1;
                                if (stat.block_full)
                                begin
                                    state_next = ST_ROUNDS;
                                end
                            end
                        end
                        OP_FINISH:
                        begin
                            if (done_reg)
                            begin
                                state_next = ST_REJECT;
                            end
                            else
                            begin
                                state_next = ST_PAD_BYTE;
                            end
                        end
                        OP_RESTART:
                        begin
                            cmd.restart = 1'b1;
                            done_next   = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_ROUNDS, ST_FINAL_ROUNDS:
            begin
                // first cycle here, marked by idx_reg zero, loads the block via start_block
                if (idx_reg == 3'd0)
                begin
                    cmd.start_block = 1'b1;
                    idx_next        = 3'd1;
                end
                else
                begin
                    cmd.round = 1'b1;
                    if (stat.last_round)
                    begin
                        idx_next = 3'd2;
                    end
                end
                if (idx_reg == 3'd2)
                begin
                    cmd.round = 1'b0;
                    cmd.fold  = 1'b1;
                    idx_next  = 3'd0;
                    if (state_reg == ST_ROUNDS)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (extra_reg)
                    begin
                        extra_next = 1'b0;
                        state_next = ST_PAD_ZERO;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_PAD_BYTE:
            begin
                cmd.wr_byte = 1'b1;
                cmd.wr_data = PadByte;
                extra_next  = (stat.fill >= LenOffset);
                if (stat.fill == 6'd63)
                begin
                    state_next = ST_FINAL_ROUNDS;
                end
                else
                begin
                    state_next = ST_PAD_ZERO;
                end
            end
            ST_PAD_ZERO:
            begin
                if (!extra_reg && stat.fill == LenOffset)
                begin
                    len_next   = '0;
                    state_next = ST_PAD_LEN;
                end
                else
                begin
                    cmd.wr_byte = 1'b1;
                    cmd.wr_data = '0;
                    if (stat.fill == 6'd63)
                    begin
                        state_next = ST_FINAL_ROUNDS;
                    end
                end
            end
            ST_PAD_LEN:
            begin
                cmd.wr_byte = 1'b1;
                cmd.wr_data = stat.total_bits[8*(7-len_reg) +: 8];
                len_next    = len_reg + 3'd1;
                if (len_reg == 3'd7)
                begin
                    state_next = ST_FINAL_ROUNDS;
                end
            end
            ST_EMIT:
            begin
                cmd.clear_fill       = 1'b1;
                done_next            = 1'b1;
                out_valid            = 1'b1;
                out_item.digest_word = rd_word;
                out_item.word_index  = idx_reg;
                out_item.last_word   = (idx_reg == 3'd7);
                if (!out_stall)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_REJECT:
            begin
                out_valid          = 1'b1;
                out_item.last_word = 1'b1;
                out_item.status    = 1'b1;
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // no new transaction taken while a digest or reject is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !accept)
        else $error("input accepted during output");
    // finish flag only set by emitting
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(state_reg) == ST_EMIT)
        else $error("finished flag set outside emit");
    // the last digest word ends the emit run
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_valid && !out_stall && idx_reg == 3'd7)
        |=> state_reg == ST_IDLE)
        else $error("emit did not end after word seven");

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// tb: self-checking testbench for sha256_hasher_top, with a sha-256 predictor
// depends on sha_pkg and sha256_hasher_top
module tb;
    import sha_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_item_t in_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_item_t out_item;

    sha256_hasher_top dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_item(in_item), .out_valid(out_valid), .out_stall(out_stall),
        .out_item(out_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic [31:0] hash_state [8];
    logic [7:0]  msg_block [64];
    logic [5:0]  fill_count;
    logic [63:0] bit_count;
    logic        digest_done;

    out_item_t digest_queue [$];
    int errors = 0;
    bit idle_ok = 1'b1;

    function automatic logic [31:0] ror(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    task automatic hash_restart();
        for (int i = 0; i < 8; i++) hash_state[i] = InitH[i];
        fill_count = '0;
        bit_count = '0;
        digest_done = 1'b0;
    endtask

    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, x, y, e, a;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (int i = 16; i < 64; i++)
        begin
            x = w[i-15];
            y = w[i-2];
            w[i] = w[i-16] + (ror(x, 7) ^ ror(x, 18) ^ (x >> 3)) + w[i-7]
                 + (ror(y, 17) ^ ror(y, 19) ^ (y >> 10));
        end
        for (int i = 0; i < 8; i++) v[i] = hash_state[i];
        for (int i = 0; i < 64; i++)
        begin
            e = v[4];
            a = v[0];
            t1 = v[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & v[5]) ^ (~e & v[6]))
               + RoundK[i] + w[i];
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = e; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = a; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] += v[i];
    endtask

    task automatic predict_digest(input in_item_t it);
        int n;
        out_item_t r;
        case (opcode_t'(it.opcode))
            OP_RESTART: hash_restart();
            OP_APPEND, OP_FINISH:
            begin
                if (digest_done)
                begin
                    r = '{digest_word: '0, word_index: '0, last_word: 1'b1, status: 1'b1};
                    digest_queue.push_back(r);
                end
                else if (it.opcode == OP_APPEND)
                begin
                    msg_block[fill_count] = it.data_byte;
                    fill_count++;
                    bit_count += 8;
                    if (fill_count == 0) compress_block();
                end
                else
                begin
                    n = fill_count;
                    msg_block[n] = PadByte;
                    n++;
                    if (n > 56)
                    begin
                        while (n < 64) msg_block[n++] = 8'h00;
                        compress_block();
                        n = 0;
                    end
                    while (n < 56) msg_block[n++] = 8'h00;
                    for (int i = 0; i < 8; i++) msg_block[56+i] = bit_count[63-8*i -: 8];
                    compress_block();
                    fill_count = '0;
                    digest_done = 1'b1;
                    for (int i = 0; i < 8; i++)
                    begin
                        r = '{digest_word: hash_state[i], word_index: 3'(i),
                              last_word: (i == 7), status: 1'b0};
                        digest_queue.push_back(r);
                    end
                end
            end
            default: ;
        endcase
    endtask

    function automatic bit take_gap();
        return !idle_ok ? 1'b0 : ($urandom_range(99) < 32);
    endfunction

    task automatic send_item(input opcode_t op, input logic [7:0] b);
        while (take_gap())
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_item = '{opcode: op, data_byte: b};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_digest('{opcode: op, data_byte: b});
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (digest_queue.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic send_bytes(input int count);
        for (int i = 0; i < count; i++) send_item(OP_APPEND, 8'($urandom));
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (digest_queue.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, out_item);
                errors++;
            end
            else
            begin
                out_item_t exp_r;
                exp_r = digest_queue.pop_front();
                if (out_item !== exp_r)
                begin
                    $display("%0t: mismatch expected word=%h idx=%0d last=%b st=%b actual word=%h idx=%0d last=%b st=%b",
                             $time, exp_r.digest_word, exp_r.word_index, exp_r.last_word,
                             exp_r.status, out_item.digest_word, out_item.word_index,
                             out_item.last_word, out_item.status);
                    errors++;
                end
            end
        end
    end

    always @(negedge clk) out_stall <= take_gap();

    task automatic test_empty_and_rejects();
        send_item(OP_FINISH, 8'h00);
        send_item(OP_APPEND, 8'hff);
        send_item(OP_FINISH, 8'h00);
        send_item(OP_NONE, 8'h5a);
        send_item(OP_RESTART, 8'hff);
    endtask

    task automatic test_abc_and_edges();
        send_item(OP_APPEND, 8'h61);
        send_item(OP_APPEND, 8'h62);
        send_item(OP_APPEND, 8'h63);
        send_item(OP_APPEND, 8'h00);
        send_item(OP_APPEND, 8'hff);
        send_item(OP_NONE, 8'h00);
        send_item(OP_FINISH, 8'hff);
        send_item(OP_RESTART, 8'h00);
    endtask

    // lengths around the extra padding block boundary
    task automatic test_pad_boundaries();
        int lens [4] = '{55, 56, 63, 64};
        foreach (lens[k])
        begin
            send_bytes(lens[k]);
            send_item(OP_FINISH, 8'h00);
            send_item(OP_RESTART, 8'h00);
        end
        wait_drained();
    endtask

    task automatic test_random_messages();
        int sent;
        int r;
        sent = 0;
        while (sent < 72)
        begin
            idle_ok = !(sent > 20 && sent < 52);
            r = $urandom_range(99);
            if (r < 85)
            begin
                send_item(OP_APPEND, 8'($urandom));
            end
            else if (r < 94)
            begin
                send_item(OP_FINISH, 8'($urandom));
                send_item(OP_RESTART, 8'($urandom));
                sent++;
            end
            else if (r < 97)
            begin
                send_item(opcode_t'($urandom_range(1, 0)), 8'($urandom));
            end
            else
            begin
                send_item(OP_NONE, 8'($urandom));
            end
            sent++;
        end
        idle_ok = 1'b1;
        send_item(OP_FINISH, 8'h00);
    endtask

    initial
    begin
        hash_restart();
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_empty_and_rejects();
        test_abc_and_edges();
        wait_drained();
        test_pad_boundaries();
        test_random_messages();
        wait_drained();
        if (errors == 0 && digest_queue.size() == 0)
            $display("sha256_hasher_top test passed");
        else
            $display("sha256_hasher_top test failed");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("sha256_hasher_top test failed");
        $finish;
    end
endmodule
